// ===== sv/vsf_pkg.sv =====
// Package for the vertical seam finder: shared widths, register indexes,
// the sequencer state type and the configuration status struct.
// No dependencies; every other file of the block uses it.
package vsf_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int ENERGY_W    = 8;
  localparam int ENERGY_BITS = 8;
  localparam logic [ENERGY_W-1:0] ENERGY_MASK = ENERGY_W'((1 << ENERGY_BITS) - 1);

  localparam int COST_W = 14;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam int SEAM_ROW_W = 6;
  localparam int SEAM_COL_W = 8;

  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int WIDTH_REG_W  = 9;
  localparam int HEIGHT_REG_W = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 9'd256;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH0,
    ST_FETCH,
    ST_CALC,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_EMIT,
    ST_BT_CENTER,
    ST_BT_LEFT,
    ST_BT_RIGHT,
    ST_BT_PICK
  } seq_state_t;

  // Effective (clamped) image size and a pulse on every valid width or height register write.
  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
    logic                    restart;
  } cfg_state_t;

endpackage

// ===== sv/vsf_in_if.sv =====
// Pixel input channel of the vertical seam finder: one energy word per pixel.
// Depends on vsf_pkg.
interface vsf_in_if;
  logic                          valid;
  logic                          ready;
  logic [vsf_pkg::ENERGY_W-1:0]  energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

// ===== sv/vsf_out_if.sv =====
// Seam result channel of the vertical seam finder: one word per image row.
// Depends on vsf_pkg.
interface vsf_out_if;
  logic                            valid;
  logic                            ready;
  logic [vsf_pkg::SEAM_ROW_W-1:0]  seam_row;
  logic [vsf_pkg::SEAM_COL_W-1:0]  seam_column;
  logic                            last_of_seam;

  modport source (output valid, output seam_row, output seam_column, output last_of_seam,
                  input ready);
  modport sink   (input valid, input seam_row, input seam_column, input last_of_seam,
                  output ready);
endinterface

// ===== sv/vsf_cfg_if.sv =====
// Configuration write channel of the vertical seam finder.
// Depends on vsf_pkg.
interface vsf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vsf_pkg::CFG_INDEX_W-1:0]  index;
  logic [vsf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/vsf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on vsf_pkg for default sizes only.
module vsf_ram #(
  parameter int WIDTH = vsf_pkg::COST_W,
  parameter int DEPTH = vsf_pkg::MAX_WIDTH_DEF * vsf_pkg::MAX_HEIGHT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/vsf_cfg.sv =====
// Configuration registers of the vertical seam finder: image width and height,
// clamped to the supported range, plus a restart pulse. Depends on vsf_pkg, vsf_cfg_if.
module vsf_cfg #(
  parameter int MAX_WIDTH  = vsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  vsf_cfg_if.sink             cfg_ch,
  output vsf_pkg::cfg_state_t cfg_o
);

  logic [vsf_pkg::WIDTH_REG_W-1:0]  width_r, width_nxt;
  logic [vsf_pkg::HEIGHT_REG_W-1:0] height_r, height_nxt;
  logic                             wr_width, wr_height;

  assign cfg_ch.ready = 1'b1;
  assign wr_width  = cfg_ch.valid && (cfg_ch.index == vsf_pkg::REG_IMAGE_WIDTH);
  assign wr_height = cfg_ch.valid && (cfg_ch.index == vsf_pkg::REG_IMAGE_HEIGHT);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_width) begin
      width_nxt = cfg_ch.data[vsf_pkg::WIDTH_REG_W-1:0];
    end
    if (wr_height) begin
      height_nxt = cfg_ch.data[vsf_pkg::HEIGHT_REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= vsf_pkg::WIDTH_RESET;
      height_r <= vsf_pkg::HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // A zero size acts as one; anything above the storage size acts as the maximum.
  always_comb begin
    cfg_o.restart = wr_width || wr_height;
    if (width_r == '0) begin
      cfg_o.width = vsf_pkg::WIDTH_REG_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      cfg_o.width = vsf_pkg::WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      cfg_o.width = width_r;
    end
    if (height_r == '0) begin
      cfg_o.height = vsf_pkg::HEIGHT_REG_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      cfg_o.height = vsf_pkg::HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      cfg_o.height = height_r;
    end
  end

endmodule

// ===== sv/vertical_seam_finder_core.sv =====
// Vertical seam finder: cumulative-cost dynamic program, bottom-row minimum
// search and backtrack. Depends on vsf_pkg, the three channel interfaces,
// vsf_cfg and vsf_ram.
//
// Usage:
//   in_ch carries one energy word per pixel in raster order, row 0 first.
//   cfg_ch writes image_width (index 0) and image_height (index 1); any such
//   write restarts loading at row 0, column 0. Write only while the block is idle.
//   out_ch returns one seam word per row after the last pixel of an image,
//   bottom row first; last_of_seam marks the row-0 word.
// Pixel handling: every pixel is a read-modify-write on the single cost RAM, and no
//   new pixel is accepted until the previous one's cost is written. A row-0 pixel
//   needs no read; others read the row above, two cells at column 0 on the one port.
// Result order: once the last pixel's cost is written, the bottom row is scanned for
//   its minimum, then the first seam word is shown; each further word is shown after
//   the previous one is taken and a backtrack step has run (three RAM reads of the row
//   above and one pick state).
// Stall: a seam word holds on out_ch until taken; no pixel is accepted from the
//   last pixel of an image until its final seam word is taken.
// Reset: width 256, height 64, load position at row 0, column 0. The cost RAM
//   is not cleared; a cell's value is only used after the current image wrote it.
module vertical_seam_finder_core #(
  parameter int MAX_WIDTH  = vsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vsf_pkg::MAX_HEIGHT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  vsf_in_if.sink     in_ch,
  vsf_out_if.source  out_ch,
  vsf_cfg_if.sink    cfg_ch
);

  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COST_W     = vsf_pkg::COST_W;
  localparam int ENERGY_W   = vsf_pkg::ENERGY_W;
  localparam int SEAM_ROW_W = vsf_pkg::SEAM_ROW_W;
  localparam int SEAM_COL_W = vsf_pkg::SEAM_COL_W;

  vsf_pkg::cfg_state_t cfg_s;
  vsf_pkg::seq_state_t state_r, state_nxt;

  logic [COL_W:0]        width_e;
  logic [ROW_W:0]        height_e;
  logic [ROW_W:0]        height_m1;

  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ENERGY_W-1:0]   energy_r, energy_nxt;
  logic [COST_W-1:0]     win_l_r, win_l_nxt;
  logic [COST_W-1:0]     win_m_r, win_m_nxt;
  logic [COST_W-1:0]     win_r_r, win_r_nxt;
  logic [COL_W-1:0]      scan_col_r, scan_col_nxt;
  logic [COST_W-1:0]     best_r, best_nxt;
  logic [ROW_W-1:0]      trace_row_r, trace_row_nxt;
  logic [COL_W-1:0]      trace_col_r, trace_col_nxt;
  logic [COL_W-1:0]      pick_col_r, pick_col_nxt;

  logic                  wrap;
  logic [ROW_W-1:0]      cur_row;
  logic [COL_W-1:0]      cur_col;
  logic [COL_W:0]        col_inc;
  logic [ROW_W:0]        row_inc;
  logic [COL_W:0]        scan_inc;
  logic [COL_W:0]        tcol_inc;
  logic                  has_right;
  logic                  has_below;
  logic                  t_has_left;
  logic                  t_has_right;
  logic [COL_W-1:0]      take_idx;

  logic [COST_W-1:0]     min_c;
  logic [COST_W:0]       sum_c;
  logic [COST_W-1:0]     cost_c;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [COST_W-1:0]     rd_data;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * MAX_WIDTH + int'(c));
  endfunction

  vsf_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg_s)
  );

  vsf_ram #(
    .WIDTH (COST_W),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cost_c),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Clamped sizes never exceed the storage size, so they fit these widths.
  assign width_e   = (COL_W + 1)'(cfg_s.width);
  assign height_e  = (ROW_W + 1)'(cfg_s.height);
  assign height_m1 = height_e - 1'b1;

  assign wrap    = ({1'b0, row_r} >= height_e) || ({1'b0, col_r} >= width_e);
  assign cur_row = wrap ? '0 : row_r;
  assign cur_col = wrap ? '0 : col_r;

  assign col_inc     = {1'b0, col_r} + 1'b1;
  assign row_inc     = {1'b0, row_r} + 1'b1;
  assign scan_inc    = {1'b0, scan_col_r} + 1'b1;
  assign tcol_inc    = {1'b0, trace_col_r} + 1'b1;
  assign has_right   = col_inc < width_e;
  assign has_below   = row_inc < height_e;
  assign t_has_left  = trace_col_r != '0;
  assign t_has_right = tcol_inc < width_e;
  assign take_idx    = (state_r == vsf_pkg::ST_SCAN) ? scan_col_r - 1'b1 : scan_col_r;

  // The right neighbor above arrives straight from the RAM in the compute cycle.
  always_comb begin
    min_c = win_m_r;
    if (col_r != '0 && win_l_r < min_c) begin
      min_c = win_l_r;
    end
    if (has_right && rd_data < min_c) begin
      min_c = rd_data;
    end
    if (row_r == '0) begin
      sum_c = (COST_W + 1)'(energy_r);
    end else begin
      sum_c = {1'b0, min_c} + (COST_W + 1)'(energy_r);
    end
    cost_c = (sum_c > {1'b0, vsf_pkg::COST_MAX}) ? vsf_pkg::COST_MAX : sum_c[COST_W-1:0];
  end

  assign ram_waddr = cell_addr(row_r, col_r);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    energy_nxt    = energy_r;
    win_l_nxt     = win_l_r;
    win_m_nxt     = win_m_r;
    win_r_nxt     = win_r_r;
    scan_col_nxt  = scan_col_r;
    best_nxt      = best_r;
    trace_row_nxt = trace_row_r;
    trace_col_nxt = trace_col_r;
    pick_col_nxt  = pick_col_r;
    ram_we        = 1'b0;
    ram_raddr     = '0;
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;

    case (state_r)
      vsf_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          energy_nxt = in_ch.energy & vsf_pkg::ENERGY_MASK;
          row_nxt    = cur_row;
          col_nxt    = cur_col;
          if (cur_row == '0) begin
            state_nxt = vsf_pkg::ST_CALC;
          end else if (cur_col == '0) begin
            state_nxt = vsf_pkg::ST_FETCH0;
          end else begin
            state_nxt = vsf_pkg::ST_FETCH;
          end
        end
      end
      vsf_pkg::ST_FETCH0: begin
        ram_raddr = cell_addr(row_r - 1'b1, '0);
        state_nxt = vsf_pkg::ST_FETCH;
      end
      vsf_pkg::ST_FETCH: begin
        // The three-cell window over the row above slides by one column per pixel.
        ram_raddr = cell_addr(row_r - 1'b1, col_inc[COL_W-1:0]);
        if (col_r == '0) begin
          win_m_nxt = rd_data;
        end else begin
          win_l_nxt = win_m_r;
          win_m_nxt = win_r_r;
        end
        state_nxt = vsf_pkg::ST_CALC;
      end
      vsf_pkg::ST_CALC: begin
        ram_we    = 1'b1;
        win_r_nxt = rd_data;
        if (has_right) begin
          col_nxt   = col_inc[COL_W-1:0];
          state_nxt = vsf_pkg::ST_IDLE;
        end else if (has_below) begin
          row_nxt   = row_inc[ROW_W-1:0];
          col_nxt   = '0;
          state_nxt = vsf_pkg::ST_IDLE;
        end else begin
          row_nxt      = '0;
          col_nxt      = '0;
          scan_col_nxt = '0;
          state_nxt    = vsf_pkg::ST_SCAN;
        end
      end
      vsf_pkg::ST_SCAN: begin
        // Reads run one column ahead of the compare.
        ram_raddr = cell_addr(height_m1[ROW_W-1:0], scan_col_r);
        if (scan_col_r != '0) begin
          if (take_idx == '0 || rd_data < best_r) begin
            best_nxt      = rd_data;
            trace_col_nxt = take_idx;
          end
        end
        if (scan_inc < width_e) begin
          scan_col_nxt = scan_inc[COL_W-1:0];
        end else begin
          state_nxt = vsf_pkg::ST_SCAN_LAST;
        end
      end
      vsf_pkg::ST_SCAN_LAST: begin
        if (take_idx == '0 || rd_data < best_r) begin
          best_nxt      = rd_data;
          trace_col_nxt = take_idx;
        end
        trace_row_nxt = height_m1[ROW_W-1:0];
        state_nxt     = vsf_pkg::ST_EMIT;
      end
      vsf_pkg::ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (trace_row_r == '0) begin
            state_nxt = vsf_pkg::ST_IDLE;
          end else begin
            state_nxt = vsf_pkg::ST_BT_CENTER;
          end
        end
      end
      vsf_pkg::ST_BT_CENTER: begin
        ram_raddr = cell_addr(trace_row_r - 1'b1, trace_col_r);
        state_nxt = vsf_pkg::ST_BT_LEFT;
      end
      vsf_pkg::ST_BT_LEFT: begin
        ram_raddr    = cell_addr(trace_row_r - 1'b1,
                                 t_has_left ? trace_col_r - 1'b1 : trace_col_r);
        best_nxt     = rd_data;
        pick_col_nxt = trace_col_r;
        state_nxt    = vsf_pkg::ST_BT_RIGHT;
      end
      vsf_pkg::ST_BT_RIGHT: begin
        ram_raddr = cell_addr(trace_row_r - 1'b1, tcol_inc[COL_W-1:0]);
        if (t_has_left && rd_data < best_r) begin
          best_nxt     = rd_data;
          pick_col_nxt = trace_col_r - 1'b1;
        end
        state_nxt = vsf_pkg::ST_BT_PICK;
      end
      vsf_pkg::ST_BT_PICK: begin
        if (t_has_right && rd_data < best_r) begin
          trace_col_nxt = tcol_inc[COL_W-1:0];
        end else begin
          trace_col_nxt = pick_col_r;
        end
        trace_row_nxt = trace_row_r - 1'b1;
        state_nxt     = vsf_pkg::ST_EMIT;
      end
      default: begin
        state_nxt = vsf_pkg::ST_IDLE;
      end
    endcase

    if (cfg_s.restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  assign out_ch.seam_row     = SEAM_ROW_W'(trace_row_r);
  assign out_ch.seam_column  = SEAM_COL_W'(trace_col_r);
  assign out_ch.last_of_seam = (trace_row_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vsf_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    energy_r    <= energy_nxt;
    win_l_r     <= win_l_nxt;
    win_m_r     <= win_m_nxt;
    win_r_r     <= win_r_nxt;
    scan_col_r  <= scan_col_nxt;
    best_r      <= best_nxt;
    trace_row_r <= trace_row_nxt;
    trace_col_r <= trace_col_nxt;
    pick_col_r  <= pick_col_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("pixel input open while a seam word is pending");

  a_seam_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_of_seam |=>
      state_r == vsf_pkg::ST_IDLE && row_r == '0 && col_r == '0)
    else $error("load position not back at the origin after the seam");

  a_word_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last_of_seam |=> !out_ch.valid)
    else $error("next seam word shown before its backtrack step");

  a_seam_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vsf_pkg::ST_BT_PICK |=>
      trace_col_r == $past(trace_col_r) ||
      trace_col_r == $past(trace_col_r) + 1'b1 ||
      trace_col_r == $past(trace_col_r) - 1'b1)
    else $error("seam moved by more than one column between rows");

  a_fetch_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == vsf_pkg::ST_CALC && row_r != '0 |-> $past(state_r) == vsf_pkg::ST_FETCH)
    else $error("cost computed without reading the row above");

endmodule

// ===== tb/sv/vertical_seam_finder_checker.sv =====
`timescale 1ns / 100ps
// Seam checker for vertical_seam_finder_core: follows register writes and accepted
// pixel words, predicts every seam word and compares each returned word with it.
// Depends on vsf_pkg and the three channel interfaces.
module vertical_seam_finder_checker #(
  parameter int MAX_WIDTH  = vsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vsf_pkg::MAX_HEIGHT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  vsf_in_if    pixel_ch,
  vsf_out_if   seam_ch,
  vsf_cfg_if   reg_ch,
  output int   mismatches,
  output int   seams_pending
);
  import vsf_pkg::*;

  typedef struct packed {
    logic [SEAM_ROW_W-1:0] seam_row;
    logic [SEAM_COL_W-1:0] seam_column;
    logic                  last_of_seam;
  } seam_word_t;

  logic [COST_W-1:0]       path_cost [MAX_HEIGHT][MAX_WIDTH];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [SEAM_COL_W-1:0]   next_column;
  logic [SEAM_ROW_W-1:0]   next_row;
  seam_word_t              pending_seam_q[$];
  seam_word_t              oldest;

  function automatic int unsigned clamp_size(input int unsigned size, input int unsigned limit);
    if (size < 1) return 1;
    if (size > limit) return limit;
    return size;
  endfunction

  // Adds the cumulative cost of one pixel. On the last pixel of the image it
  // starts from the cheapest bottom cell and queues one seam word per row.
  task automatic accumulate_pixel(input logic [ENERGY_W-1:0] energy);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned j;
    int unsigned centre;
    int unsigned cost;
    int row;
    logic [COST_W-1:0] low;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    r = next_row;
    c = next_column;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    cost = energy & ENERGY_MASK;
    if (r > 0) begin
      low = path_cost[r-1][c];
      if (c > 0 && path_cost[r-1][c-1] < low) low = path_cost[r-1][c-1];
      if (c + 1 < w && path_cost[r-1][c+1] < low) low = path_cost[r-1][c+1];
      cost += low;
    end
    if (cost > COST_MAX) cost = COST_MAX;
    path_cost[r][c] = cost[COST_W-1:0];

    if (c + 1 < w) begin
      next_column = SEAM_COL_W'(c + 1);
      next_row = SEAM_ROW_W'(r);
    end else if (r + 1 < h) begin
      next_column = '0;
      next_row = SEAM_ROW_W'(r + 1);
    end else begin
      next_column = '0;
      next_row = '0;
      c = 0;
      low = path_cost[h-1][0];
      for (j = 1; j < w; j++) begin
        if (path_cost[h-1][j] < low) begin
          low = path_cost[h-1][j];
          c = j;
        end
      end
      // Going up, the centre cell wins ties, then the left one, then the right one.
      for (row = h - 1; row >= 0; row--) begin
        pending_seam_q.push_back('{SEAM_ROW_W'(row), SEAM_COL_W'(c), row == 0});
        if (row > 0) begin
          centre = c;
          low = path_cost[row-1][centre];
          if (centre > 0 && path_cost[row-1][centre-1] < low) begin
            low = path_cost[row-1][centre-1];
            c = centre - 1;
          end
          if (centre + 1 < w && path_cost[row-1][centre+1] < low) c = centre + 1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      next_column = '0;
      next_row = '0;
      pending_seam_q.delete();
      mismatches = 0;
    end else begin
      if (seam_ch.valid && seam_ch.ready) begin
        if (pending_seam_q.size() == 0) begin
          if (mismatches < 10)
            $display("seam word with none predicted: row %0d column %0d last %0b",
                     seam_ch.seam_row, seam_ch.seam_column, seam_ch.last_of_seam);
          mismatches++;
        end else begin
          oldest = pending_seam_q.pop_front();
          if (oldest.seam_row !== seam_ch.seam_row ||
              oldest.seam_column !== seam_ch.seam_column ||
              oldest.last_of_seam !== seam_ch.last_of_seam) begin
            if (mismatches < 10)
              $display("seam word mismatch: expected row %0d column %0d last %0b, got %0d %0d %0b",
                       oldest.seam_row, oldest.seam_column, oldest.last_of_seam,
                       seam_ch.seam_row, seam_ch.seam_column, seam_ch.last_of_seam);
            mismatches++;
          end
        end
      end
      // A write to either size register restarts loading; other indexes do nothing.
      if (reg_ch.valid && reg_ch.ready) begin
        case (reg_ch.index)
          REG_IMAGE_WIDTH: begin
            width_reg = reg_ch.data[WIDTH_REG_W-1:0];
            next_column = '0;
            next_row = '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = reg_ch.data[HEIGHT_REG_W-1:0];
            next_column = '0;
            next_row = '0;
          end
          default: ;
        endcase
      end
      if (pixel_ch.valid && pixel_ch.ready) accumulate_pixel(pixel_ch.energy);
    end
    seams_pending <= pending_seam_q.size();
  end

endmodule

// ===== tb/sv/vertical_seam_finder_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the vertical seam finder testbench: clock, reset, register and pixel
// stimulus, seam back-pressure and the verdict. Depends on vsf_pkg, the channel
// interfaces, vertical_seam_finder_core and vertical_seam_finder_checker.
module vertical_seam_finder_core_tb;
  import vsf_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 300;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int RANDOM_PIXELS = 25;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // 4x3 image, row 0 first: the seam must prefer the centre over an equal left cell.
  localparam logic [12*8-1:0] RIDGE_IMAGE = {
    8'd255, 8'd0,   8'd0,   8'd255,
    8'd255, 8'd255, 8'd0,   8'd255,
    8'd0,   8'd255, 8'd255, 8'd0
  };

  logic clk;
  logic rst_n;
  int   mismatches;
  int   seams_pending;
  int   cycle_count = 0;
  bit   pixel_gaps;
  bit   seam_stalls;

  vsf_in_if  in_ch();
  vsf_out_if out_ch();
  vsf_cfg_if cfg_ch();

  vertical_seam_finder_core DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  vertical_seam_finder_checker seam_checker (
    .clk(clk), .rst_n(rst_n), .pixel_ch(in_ch), .seam_ch(out_ch), .reg_ch(cfg_ch),
    .mismatches(mismatches), .seams_pending(seams_pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    out_ch.ready <= !seam_stalls || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Valid stays high when the next word follows at once.
  task automatic send_pixel(input logic [ENERGY_W-1:0] energy);
    while (pixel_gaps && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.energy <= energy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the pixel stream until every predicted seam word is back, then lets the
  // block finish any pixel still in flight so that it is idle.
  task automatic flush_seams();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (seams_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends random energies; at position spare_at the block is left idle and an
  // unused register index is written, which must not disturb the load position.
  task automatic stream_energies(input int pixels, input bit tie_heavy, input int spare_at);
    int i;
    for (i = 0; i < pixels; i++) begin
      if (i == spare_at) begin
        flush_seams();
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom_range(511)));
      end
      send_pixel(tie_heavy ? ENERGY_W'($urandom_range(3)) : ENERGY_W'($urandom_range(255)));
    end
  endtask

  initial begin
    int i;
    int w;
    int h;
    int choice;
    int count;
    int images;
    int pixels;
    int phase;
    bit partial;
    in_ch.valid   = 1'b0;
    in_ch.energy  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    pixel_gaps    = 1'b1;
    seam_stalls   = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a flat image where every choice is a tie, a ridge image
    // with extreme energies, and a zero-sized image that clamps to one pixel.
    write_reg(REG_IMAGE_WIDTH, 9'd4);
    write_reg(REG_IMAGE_HEIGHT, 9'd3);
    repeat (12) send_pixel('0);
    for (i = 0; i < 12; i++) send_pixel(RIDGE_IMAGE[8*(11-i) +: 8]);
    flush_seams();
    write_reg(REG_IMAGE_WIDTH, 9'd0);
    write_reg(REG_IMAGE_HEIGHT, 9'd0);
    send_pixel(8'd255);

    // Widest image through an oversized width, then tallest through an oversized
    // height; this long stretch runs with neither side idling.
    pixel_gaps  = 1'b0;
    seam_stalls = 1'b0;
    flush_seams();
    write_reg(REG_IMAGE_WIDTH, 9'd511);
    write_reg(REG_IMAGE_HEIGHT, 9'd1);
    stream_energies(256, 1'b0, -1);
    flush_seams();
    write_reg(REG_IMAGE_WIDTH, 9'd1);
    write_reg(REG_IMAGE_HEIGHT, 9'd127);
    stream_energies(64, 1'b0, -1);
    flush_seams();
    pixel_gaps  = 1'b1;
    seam_stalls = 1'b1;

    w = 1;
    h = 64;
    pixels = 0;
    phase = 0;
    while (pixels < RANDOM_PIXELS) begin
      flush_seams();
      choice = (phase == 0) ? 2 : $urandom_range(3);
      if (choice != 1) begin
        w = ($urandom_range(99) < 15) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        write_reg(REG_IMAGE_WIDTH, (w == 1 && $urandom_range(1)) ? 9'd0 : CFG_DATA_W'(w));
      end
      if (choice != 0) begin
        h = ($urandom_range(99) < 15) ? $urandom_range(10, 7) : $urandom_range(6, 1);
        // The upper data bits lie outside the height register and are dropped.
        write_reg(REG_IMAGE_HEIGHT, {2'($urandom_range(3)),
                  (h == 1 && $urandom_range(1)) ? 7'd0 : 7'(h)});
      end
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom_range(511)));
      images = $urandom_range(3, 1);
      for (i = 0; i < images; i++) begin
        // An abandoned image ends the phase; the next register write restarts loading.
        partial = (w * h > 1) && ($urandom_range(99) < 15);
        count = partial ? $urandom_range(w * h - 1, 1) : w * h;
        stream_energies(count, $urandom_range(99) < 40,
                        ($urandom_range(99) < 15) ? $urandom_range(count - 1) : -1);
        pixels += count;
        if (partial) i = images;
        else if ($urandom_range(99) < 25) flush_seams();
      end
      phase++;
    end

    flush_seams();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && seams_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
